>>> sv/imu_gmd_pkg.sv
package imu_gmd_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int THRESH_W  = 16;
    localparam int SUM_OUT_W = 24;
    localparam int DIR_W     = 2;
    localparam int AXES      = 3;

    localparam int IN_TDATA_W  = 6 * SAMPLE_W;
    // 1 + 1 + 2 + 1 + 3 * 24 = 77 bits, padded to 80
    localparam int OUT_FIELD_W = 5 + AXES * SUM_OUT_W;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_ACCEL_THRESHOLD = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_GYRO_THRESHOLD  = CFG_INDEX_W'(1);

    localparam logic [THRESH_W-1:0] ACCEL_THRESHOLD_RST = 16'd3279;
    localparam logic [THRESH_W-1:0] GYRO_THRESHOLD_RST  = 16'd571;

    localparam logic [DIR_W-1:0] DIR_STOPPED = 2'b00;
    localparam logic [DIR_W-1:0] DIR_OPENING = 2'b01;
    localparam logic [DIR_W-1:0] DIR_CLOSING = 2'b11;

    typedef struct packed {
        logic step;    // item accepted this cycle
        logic primed;  // a previous sample is held
        logic clear;   // episode ends: zero the accumulators
    } lane_ctrl_t;

endpackage

>>> sv/imu_gmd_gyro_lane.sv
module imu_gmd_gyro_lane
    import imu_gmd_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  lane_ctrl_t                 ctrl,
    input  logic signed [SAMPLE_W-1:0] sample,
    input  logic        [THRESH_W-1:0] threshold,
    output logic                       exceed
);

    logic signed [SAMPLE_W-1:0] last_reg;
    logic signed [SAMPLE_W-1:0] last_next;
    logic signed [SAMPLE_W:0]   diff;
    logic        [SAMPLE_W:0]   magn;

    always_comb
    begin
        diff      = {last_reg[SAMPLE_W-1], last_reg} - {sample[SAMPLE_W-1], sample};
        magn      = diff[SAMPLE_W] ? (~diff + 1'b1) : diff;
        exceed    = ctrl.primed && (magn > {1'b0, threshold});
        last_next = ctrl.step ? sample : last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg <= '0;
        end
        else
        begin
            last_reg <= last_next;
        end
    end

endmodule

>>> sv/imu_gmd_accel_lane.sv
module imu_gmd_accel_lane
    import imu_gmd_pkg::*;
#(
    parameter int SUM_WIDTH = 24
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  lane_ctrl_t                  ctrl,
    input  logic signed [SAMPLE_W-1:0]  sample,
    input  logic        [THRESH_W-1:0]  threshold,
    output logic                        exceed,
    output logic signed [SUM_WIDTH-1:0] sum_next
);

    localparam logic signed [SUM_WIDTH-1:0] SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
    localparam logic signed [SUM_WIDTH-1:0] SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};

    logic signed [SAMPLE_W-1:0]  last_reg;
    logic signed [SAMPLE_W-1:0]  last_next;
    logic signed [SUM_WIDTH-1:0] sum_reg;
    logic signed [SAMPLE_W:0]    diff;
    logic        [SAMPLE_W:0]    magn;
    logic signed [SUM_WIDTH:0]   sum_ext;
    logic signed [SUM_WIDTH-1:0] sum_sat;

    always_comb
    begin
        diff    = {last_reg[SAMPLE_W-1], last_reg} - {sample[SAMPLE_W-1], sample};
        magn    = diff[SAMPLE_W] ? (~diff + 1'b1) : diff;
        exceed  = ctrl.primed && (magn > {1'b0, threshold});
        sum_ext = {sum_reg[SUM_WIDTH-1], sum_reg}
                + {{(SUM_WIDTH-SAMPLE_W){diff[SAMPLE_W]}}, diff};

        // clamp when the carry into the guard bit disagrees with the sign
        if (sum_ext[SUM_WIDTH] != sum_ext[SUM_WIDTH-1])
        begin
            sum_sat = sum_ext[SUM_WIDTH] ? SUM_MIN : SUM_MAX;
        end
        else
        begin
            sum_sat = sum_ext[SUM_WIDTH-1:0];
        end

        priority if (ctrl.clear)
        begin
            sum_next = '0;
        end
        else if (exceed)
        begin
            sum_next = sum_sat;
        end
        else
        begin
            sum_next = sum_reg;
        end

        last_next = ctrl.step ? sample : last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg <= '0;
            sum_reg  <= '0;
        end
        else
        begin
            last_reg <= last_next;
            if (ctrl.step)
            begin
                sum_reg <= sum_next;
            end
        end
    end

endmodule

>>> sv/imu_gate_motion_detector_unit.sv
// A result is registered and appears on the master side in the cycle after its sample is taken.
// Throughput: one sample per cycle unless a held result waits on master tready; the six
// axis lanes and the merge are combinational, so the accumulator loop closes through the sum registers.
// The slave side stalls only while a held result waits on master tready.
// Reset (rst_n, async, active low): thresholds return to 3279 / 571, the block
// is unprimed, accumulators and previous samples clear, direction is stopped.
module imu_gate_motion_detector_unit
    import imu_gmd_pkg::*;
#(
    parameter int SUM_WIDTH = 24
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // accel_motion, rotating, direction[1:0], reporting, sum_x, sum_y, sum_z, zero pad
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic                 in_accept;
    lane_ctrl_t           ctrl;
    logic [AXES-1:0]      accel_hit;
    logic [AXES-1:0]      gyro_hit;
    logic                 motion;
    logic                 rot;

    logic signed [SUM_WIDTH-1:0] sum_next [AXES];
    logic        [SUM_OUT_W-1:0] sum_out  [AXES];

    logic [THRESH_W-1:0]  accel_thr_reg;
    logic [THRESH_W-1:0]  gyro_thr_reg;
    logic                 primed_reg;
    logic                 episode_reg;
    logic                 episode_next;
    logic [DIR_W-1:0]     dir_reg;
    logic [DIR_W-1:0]     dir_next;

    logic                   out_valid_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;
    logic [OUT_TDATA_W-1:0] out_data_next;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    assign rot          = |gyro_hit;
    assign motion       = |accel_hit;
    assign ctrl.step    = in_accept;
    assign ctrl.primed  = primed_reg;
    assign ctrl.clear   = primed_reg && !rot && episode_reg;

    for (genvar i = 0; i < AXES; i++)
    begin : g_lane
        imu_gmd_accel_lane #(
            .SUM_WIDTH (SUM_WIDTH)
        ) u_accel (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .sample    (s_axis_tdata[i*SAMPLE_W +: SAMPLE_W]),
            .threshold (accel_thr_reg),
            .exceed    (accel_hit[i]),
            .sum_next  (sum_next[i])
        );

        imu_gmd_gyro_lane u_gyro (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .sample    (s_axis_tdata[(AXES+i)*SAMPLE_W +: SAMPLE_W]),
            .threshold (gyro_thr_reg),
            .exceed    (gyro_hit[i])
        );

        if (SUM_WIDTH >= SUM_OUT_W)
        begin : g_trunc
            assign sum_out[i] = sum_next[i][SUM_OUT_W-1:0];
        end
        else
        begin : g_sext
            assign sum_out[i] = {{(SUM_OUT_W-SUM_WIDTH){sum_next[i][SUM_WIDTH-1]}},
                                 sum_next[i]};
        end
    end

    // merge: episode tracking, direction from the X accumulator and the output word
    always_comb
    begin
        episode_next = episode_reg;
        dir_next     = dir_reg;
        if (primed_reg)
        begin
            if (rot)
            begin
                episode_next = 1'b1;
                priority if (sum_next[0] > 0)
                begin
                    dir_next = DIR_OPENING;
                end
                else if (sum_next[0] < 0)
                begin
                    dir_next = DIR_CLOSING;
                end
                else
                begin
                    dir_next = DIR_STOPPED;
                end
            end
            else
            begin
                episode_next = 1'b0;
            end
        end

        out_data_next = '0;
        out_data_next[0]   = motion;
        out_data_next[1]   = rot;
        out_data_next[3:2] = dir_next;
        out_data_next[4]   = episode_next;
        for (int i = 0; i < AXES; i++)
        begin
            out_data_next[5 + i*SUM_OUT_W +: SUM_OUT_W] = sum_out[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accel_thr_reg <= ACCEL_THRESHOLD_RST;
            gyro_thr_reg  <= GYRO_THRESHOLD_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            // drop writes to unknown indexes
            if (cfg_index == REG_ACCEL_THRESHOLD)
            begin
                accel_thr_reg <= cfg_data;
            end
            else if (cfg_index == REG_GYRO_THRESHOLD)
            begin
                gyro_thr_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            primed_reg    <= 1'b0;
            episode_reg   <= 1'b0;
            dir_reg       <= DIR_STOPPED;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                primed_reg  <= 1'b1;
                episode_reg <= episode_next;
                dir_reg     <= dir_next;
            end
            if (in_accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            out_data_reg <= out_data_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_episode_unprimed: assert property (@(posedge clk) disable iff (!rst_n)
        !primed_reg |-> !episode_reg)
        else $error("episode active before first sample");

    a_priming_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && !primed_reg) |=> (!m_axis_tdata[0] && !m_axis_tdata[1]))
        else $error("priming transaction flagged motion");

    a_rotating_reports: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[1]) |-> m_axis_tdata[4])
        else $error("rotating without an active episode");

    a_clear_zeroes_sums: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && ctrl.clear) |=> (m_axis_tdata[5 +: AXES*SUM_OUT_W] == '0))
        else $error("accumulators not cleared at episode end");
`endif

endmodule

>>> verif/imu_gate_motion_monitor.sv
`timescale 1ns / 1ps

module imu_gate_motion_monitor
    import imu_gmd_pkg::*;
#(
    parameter int SUM_WIDTH = 24
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    input  logic                   s_axis_tready,
    // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // accel_motion, rotating, direction[1:0], reporting, sum_x, sum_y, sum_z, zero pad
    input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output int                     failures,
    output int                     pending,
    output int                     results_checked
);

    // Declared from the top field down so that accel_motion lands in bit 0.
    typedef struct packed {
        logic [SUM_OUT_W-1:0] sum_z;
        logic [SUM_OUT_W-1:0] sum_y;
        logic [SUM_OUT_W-1:0] sum_x;
        logic                 reporting;
        logic [DIR_W-1:0]     direction;
        logic                 rotating;
        logic                 accel_motion;
    } motion_report_t;

    logic [THRESH_W-1:0] accel_limit;
    logic [THRESH_W-1:0] gyro_limit;
    logic                have_prev;
    int                  prev_accel [AXES];
    int                  prev_gyro [AXES];
    longint              episode_sum [AXES];
    logic                in_motion;
    logic [DIR_W-1:0]    heading;

    motion_report_t      expected_reports [$];
    motion_report_t      want_report;
    motion_report_t      got_report;
    int                  err_total;
    int                  checked_total;

    function automatic longint clamp_sum(input longint value);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (SUM_WIDTH - 1)) - 1;
        lo = -hi - 1;
        if (value > hi)
        begin
            return hi;
        end
        if (value < lo)
        begin
            return lo;
        end
        return value;
    endfunction

    function automatic int magnitude(input int value);
        return (value < 0) ? -value : value;
    endfunction

    // Advance the gate state by one sample and return the report it produces.
    function automatic motion_report_t gate_report(input logic [IN_TDATA_W-1:0] word);
        int             acc [AXES];
        int             gyr [AXES];
        int             delta;
        logic           motion;
        logic           rot;
        motion_report_t rep;
        motion = 1'b0;
        rot    = 1'b0;
        for (int i = 0; i < AXES; i++)
        begin
            acc[i] = int'($signed(word[i*SAMPLE_W +: SAMPLE_W]));
            gyr[i] = int'($signed(word[(AXES+i)*SAMPLE_W +: SAMPLE_W]));
        end
        if (have_prev)
        begin
            for (int i = 0; i < AXES; i++)
            begin
                delta = prev_accel[i] - acc[i];
                if (magnitude(delta) > int'(accel_limit))
                begin
                    motion = 1'b1;
                    episode_sum[i] = clamp_sum(episode_sum[i] + delta);
                end
                if (magnitude(prev_gyro[i] - gyr[i]) > int'(gyro_limit))
                begin
                    rot = 1'b1;
                end
            end
            if (rot)
            begin
                if (episode_sum[0] > 0)
                begin
                    heading = DIR_OPENING;
                end
                else if (episode_sum[0] < 0)
                begin
                    heading = DIR_CLOSING;
                end
                else
                begin
                    heading = DIR_STOPPED;
                end
                in_motion = 1'b1;
            end
            else if (in_motion)
            begin
                // episode over: heading holds, sums clear
                in_motion = 1'b0;
                for (int i = 0; i < AXES; i++)
                begin
                    episode_sum[i] = 0;
                end
            end
        end
        for (int i = 0; i < AXES; i++)
        begin
            prev_accel[i] = acc[i];
            prev_gyro[i]  = gyr[i];
        end
        have_prev = 1'b1;

        rep.accel_motion = motion;
        rep.rotating     = rot;
        rep.direction    = heading;
        rep.reporting    = in_motion;
        rep.sum_x        = SUM_OUT_W'(episode_sum[0]);
        rep.sum_y        = SUM_OUT_W'(episode_sum[1]);
        rep.sum_z        = SUM_OUT_W'(episode_sum[2]);
        return rep;
    endfunction

    task automatic flag_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
            err_total++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accel_limit = ACCEL_THRESHOLD_RST;
            gyro_limit  = GYRO_THRESHOLD_RST;
            have_prev   = 1'b0;
            in_motion   = 1'b0;
            heading     = DIR_STOPPED;
            for (int i = 0; i < AXES; i++)
            begin
                prev_accel[i]  = 0;
                prev_gyro[i]   = 0;
                episode_sum[i] = 0;
            end
            expected_reports.delete();
            err_total       = 0;
            checked_total   = 0;
            failures        <= 0;
            pending         <= 0;
            results_checked <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_ACCEL_THRESHOLD: accel_limit = cfg_data;
                    REG_GYRO_THRESHOLD:  gyro_limit  = cfg_data;
                    default: ;
                endcase
            end

            // Retire the outgoing report before queueing a new sample's report.
            if (m_axis_tvalid && m_axis_tready)
            begin
                got_report = m_axis_tdata[OUT_FIELD_W-1:0];
                if (expected_reports.size() == 0)
                begin
                    $error("report transaction arrived with no sample waiting for it");
                    err_total++;
                end
                else
                begin
                    want_report = expected_reports.pop_front();
                    checked_total++;
                    flag_field("accel_motion", 32'(want_report.accel_motion),
                               32'(got_report.accel_motion));
                    flag_field("rotating", 32'(want_report.rotating),
                               32'(got_report.rotating));
                    flag_field("direction", 32'(want_report.direction),
                               32'(got_report.direction));
                    flag_field("reporting", 32'(want_report.reporting),
                               32'(got_report.reporting));
                    flag_field("sum_x", 32'(want_report.sum_x), 32'(got_report.sum_x));
                    flag_field("sum_y", 32'(want_report.sum_y), 32'(got_report.sum_y));
                    flag_field("sum_z", 32'(want_report.sum_z), 32'(got_report.sum_z));
                    flag_field("pad", '0, 32'(m_axis_tdata[OUT_TDATA_W-1:OUT_FIELD_W]));
                end
            end

            if (s_axis_tvalid && s_axis_tready)
            begin
                expected_reports.push_back(gate_report(s_axis_tdata));
            end

            failures        <= err_total;
            pending         <= expected_reports.size();
            results_checked <= checked_total;
        end
    end

endmodule

>>> verif/imu_gate_motion_detector_unit_test.sv
`timescale 1ns / 1ps

module imu_gate_motion_detector_unit_test;

    import imu_gmd_pkg::*;

    localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED_LOW  = CFG_INDEX_W'(2);
    localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED_HIGH = '1;
    localparam int SAMPLE_MAX = 32767;
    localparam int SAMPLE_MIN = -32768;
    localparam int LIMIT_MAX  = 65535;

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    // accel_motion, rotating, direction[1:0], reporting, sum_x, sum_y, sum_z, zero pad
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    int failures;
    int pending;
    int results_checked;

    bit idle_enabled;
    int last_sample [6];
    int accel_limit;
    int gyro_limit;
    int samples_sent;
    int cfg_writes;

    imu_gate_motion_detector_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    imu_gate_motion_monitor gate_monitor (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .failures        (failures),
        .pending         (pending),
        .results_checked (results_checked)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    initial
    begin
        #5_000_000;
        $display("imu_gate_motion_detector_unit_test failed");
        $finish;
    end

    // Result side: random stall bursts while idling is enabled.
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (idle_enabled && $urandom_range(0, 5) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    task automatic send_sample(input int ax, input int ay, input int az,
                               input int gx, input int gy, input int gz);
        if (idle_enabled && $urandom_range(0, 4) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {SAMPLE_W'(gz), SAMPLE_W'(gy), SAMPLE_W'(gx),
                          SAMPLE_W'(az), SAMPLE_W'(ay), SAMPLE_W'(ax)};
        do @(posedge clk); while (!s_axis_tready);
        last_sample = '{ax, ay, az, gx, gy, gz};
        samples_sent++;
    endtask

    // Hold the sample stream until every outstanding report has come back.
    task automatic pause_until_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
        cfg_writes++;
    endtask

    task automatic set_limits(input int accel_value, input int gyro_value);
        pause_until_drained();
        write_reg(REG_ACCEL_THRESHOLD, CFG_DATA_W'(accel_value));
        write_reg(REG_GYRO_THRESHOLD, CFG_DATA_W'(gyro_value));
        accel_limit = accel_value;
        gyro_limit  = gyro_value;
    endtask

    // Move one axis by a change below/at or above the given limit.
    function automatic int walk_axis(input int prev, input int limit, input bit over);
        int span;
        int step;
        int nxt;
        if (over)
        begin
            if (limit >= LIMIT_MAX)
            begin
                span = LIMIT_MAX;
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                span = limit + 1 + $urandom_range(0, LIMIT_MAX - 1 - limit);
            end
            else
            begin
                span = limit + 1 + $urandom_range(0, 300);
                if (span > LIMIT_MAX)
                begin
                    span = LIMIT_MAX;
                end
            end
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            span = limit;
        end
        else
        begin
            span = $urandom_range(0, limit);
        end
        step = $urandom_range(0, 1) ? span : -span;
        nxt  = prev + step;
        if (nxt > SAMPLE_MAX || nxt < SAMPLE_MIN)
        begin
            nxt = prev - step;
        end
        if (nxt > SAMPLE_MAX)
        begin
            nxt = SAMPLE_MAX;
        end
        if (nxt < SAMPLE_MIN)
        begin
            nxt = SAMPLE_MIN;
        end
        return nxt;
    endfunction

    task automatic random_sample(input bit moving);
        int nxt [6];
        int lead;
        lead = $urandom_range(0, 2);
        if ($urandom_range(0, 9) == 0)
        begin
            for (int i = 0; i < 6; i++)
            begin
                nxt[i] = $urandom_range(0, LIMIT_MAX) + SAMPLE_MIN;
            end
        end
        else
        begin
            for (int i = 0; i < 3; i++)
            begin
                nxt[i] = walk_axis(last_sample[i], accel_limit, $urandom_range(0, 2) == 0);
                nxt[3+i] = walk_axis(last_sample[3+i], gyro_limit,
                                     moving && (i == lead || $urandom_range(0, 3) == 0));
            end
        end
        send_sample(nxt[0], nxt[1], nxt[2], nxt[3], nxt[4], nxt[5]);
    endtask

    // Alternate moving and still stretches, mostly moving so episodes build up.
    task automatic random_episodes(input int count);
        int  left;
        int  run;
        bit  moving;
        left = count;
        while (left > 0)
        begin
            moving = ($urandom_range(0, 2) != 0);
            run    = $urandom_range(1, 12);
            for (int k = 0; k < run && left > 0; k++)
            begin
                random_sample(moving);
                left--;
            end
        end
    endtask

    // Keep rotating while X drops a full swing each round and recovers in
    // steps at or below the limit, so sum_x climbs to its ceiling and sum_y to its floor.
    task automatic saturate_episode();
        int gx;
        set_limits(32768, 0);
        send_sample(SAMPLE_MAX, SAMPLE_MIN, 0, 0, 0, 0);
        send_sample(SAMPLE_MAX, SAMPLE_MIN, 0, 0, 0, 0);
        gx = 0;
        for (int r = 0; r < 130; r++)
        begin
            gx = (gx > 0) ? -1000 : 1000;
            send_sample(SAMPLE_MIN, SAMPLE_MAX, $urandom_range(0, 32000) - 16000,
                        gx, $urandom_range(0, 200), 0);
            gx = -gx;
            send_sample(-1, 0, $urandom_range(0, 32000) - 16000,
                        gx, $urandom_range(0, 200), 0);
            gx = -gx;
            send_sample(SAMPLE_MAX, SAMPLE_MIN, $urandom_range(0, 32000) - 16000,
                        gx, $urandom_range(0, 200), 0);
        end
        // no gyro change: episode ends
        send_sample(last_sample[0], last_sample[1], last_sample[2],
                    last_sample[3], last_sample[4], last_sample[5]);
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        idle_enabled  = 1'b1;
        last_sample   = '{0, 0, 0, 0, 0, 0};
        accel_limit   = int'(ACCEL_THRESHOLD_RST);
        gyro_limit    = int'(GYRO_THRESHOLD_RST);
        samples_sent  = 0;
        cfg_writes    = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // unmapped indexes must leave the reset thresholds in place
        write_reg(REG_UNMAPPED_LOW, '0);
        write_reg(REG_UNMAPPED_HIGH, '1);

        // priming sample, then full swings both ways
        send_sample(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX);
        send_sample(SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN);
        send_sample(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX);
        // changes equal to the limits do not count
        send_sample(29488, SAMPLE_MAX, SAMPLE_MAX, 32196, SAMPLE_MAX, SAMPLE_MAX);
        // one past the limits: opening
        send_sample(26208, SAMPLE_MAX, SAMPLE_MAX, 31624, SAMPLE_MAX, SAMPLE_MAX);
        send_sample(26208, SAMPLE_MAX, SAMPLE_MAX, 31624, SAMPLE_MAX, SAMPLE_MAX);
        // closing, then the end of the episode keeps the direction
        send_sample(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, 31000, SAMPLE_MAX, SAMPLE_MAX);
        send_sample(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, 31000, SAMPLE_MAX, SAMPLE_MAX);
        // rotation with an empty X sum gives stopped
        send_sample(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, 30000, SAMPLE_MAX, SAMPLE_MAX);
        send_sample(SAMPLE_MAX, 28000, SAMPLE_MAX, 30000, 32000, SAMPLE_MAX);
        send_sample(SAMPLE_MAX, 28000, 20000, 30000, 32000, 31000);
        send_sample(SAMPLE_MAX, 28000, 20000, 30000, 32000, 31000);

        set_limits(0, 0);
        send_sample(SAMPLE_MAX, 28000, 20000, 30000, 32000, 31000);
        send_sample(32766, 28000, 20000, 29999, 32000, 31000);
        send_sample(32766, 28000, 20000, 29999, 32000, 31000);

        set_limits(LIMIT_MAX, LIMIT_MAX);
        send_sample(SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN);
        send_sample(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX);

        set_limits(int'(ACCEL_THRESHOLD_RST), int'(GYRO_THRESHOLD_RST));
        random_episodes(10);
        set_limits($urandom_range(1000, 8000), $urandom_range(100, 2000));
        random_episodes(10);
        set_limits($urandom_range(0, 255), $urandom_range(0, 255));
        random_episodes(10);
        saturate_episode();
        set_limits($urandom_range(0, LIMIT_MAX), $urandom_range(0, LIMIT_MAX));
        random_episodes(10);
        set_limits(0, 0);
        random_episodes(5);

        pause_until_drained();
        idle_enabled = 1'b0;
        set_limits($urandom_range(2000, 6000), $urandom_range(200, 1500));
        random_episodes(10);

        pause_until_drained();
        repeat (4) @(posedge clk);
        $display("Sent %0d IMU samples, checked %0d reports, made %0d register writes.",
                 samples_sent, results_checked, cfg_writes);
        $display("Covered limit extremes, unmapped writes, episodes and sum saturation.");
        if (failures == 0 && pending == 0)
        begin
            $display("imu_gate_motion_detector_unit_test passed");
        end
        else
        begin
            $display("imu_gate_motion_detector_unit_test failed");
        end
        $finish;
    end

endmodule
